[rtl/assert_macros.svh]
// Assertion macros used by the mailbox back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/pmm_pkg.sv]
// Package: constants, codes and transfer types of the port message mailbox
package pmm_pkg;

  localparam int NUM_PORTS_DEF     = 64;
  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int PAYLOAD_BYTES_DEF = 8;
  localparam int FIFO_DEPTH        = 2;

  // request action codes
  localparam logic [2:0] ACT_CREATE  = 3'd0;
  localparam logic [2:0] ACT_DESTROY = 3'd1;
  localparam logic [2:0] ACT_SEND    = 3'd2;
  localparam logic [2:0] ACT_RECV    = 3'd3;
  localparam logic [2:0] ACT_QUERY   = 3'd4;

  typedef enum logic [2:0] {
    OP_CREATE, OP_DESTROY, OP_SEND, OP_RECV, OP_QUERY, OP_BAD
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_NOFREE  = 3'd4
  } status_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t         op;
    logic [7:0]  port;
    logic        in_range;
    logic [31:0] owner_id;
    logic [31:0] sender;
    logic [31:0] msg_type;
    logic [63:0] payload;
    logic [3:0]  length;
    logic [63:0] time_now;
  } req_t;

  // one stored message
  typedef struct packed {
    logic [31:0] sender;
    logic [31:0] msg_type;
    logic [63:0] payload;
    logic [3:0]  length;
    logic [63:0] time_now;
  } msg_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  new_port;
    logic [31:0] sender_out;
    logic [31:0] receiver_out;
    logic [31:0] type_out;
    logic [63:0] payload_out;
    logic [3:0]  length_out;
    logic [63:0] time_out;
    logic [4:0]  count_out;
    logic        has_messages;
    logic [6:0]  active_ports;
  } rsp_t;

endpackage

[rtl/pmm_if.sv]
// Request and response channel interfaces
interface pmm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  port;
  logic [31:0] owner_id;
  logic [31:0] sender;
  logic [31:0] msg_type;
  logic [63:0] payload;
  logic [7:0]  length;
  logic [63:0] time_now;
  modport source (output valid, action, port, owner_id, sender, msg_type, payload, length,
                  time_now, input ready);
  modport sink (input valid, action, port, owner_id, sender, msg_type, payload, length,
                time_now, output ready);
endinterface

interface pmm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  new_port;
  logic [31:0] sender_out;
  logic [31:0] receiver_out;
  logic [31:0] type_out;
  logic [63:0] payload_out;
  logic [3:0]  length_out;
  logic [63:0] time_out;
  logic [4:0]  count_out;
  logic        has_messages;
  logic [6:0]  active_ports;
  modport source (output valid, status, new_port, sender_out, receiver_out, type_out,
                  payload_out, length_out, time_out, count_out, has_messages, active_ports,
                  input ready);
  modport sink (input valid, status, new_port, sender_out, receiver_out, type_out,
                payload_out, length_out, time_out, count_out, has_messages, active_ports,
                output ready);
endinterface

[rtl/pmm_front.sv]
// Front end: accepts requests, decodes the action, clamps length, masks payload
module pmm_front #(
  parameter int NUM_PORTS     = pmm_pkg::NUM_PORTS_DEF,
  parameter int PAYLOAD_BYTES = pmm_pkg::PAYLOAD_BYTES_DEF
) (
  pmm_req_if.sink       req,
  input  logic          q_ready,
  output logic          q_valid,
  output pmm_pkg::req_t q_data
);
  import pmm_pkg::*;

  logic [3:0] len_clamped;

  assign req.ready = q_ready;
  assign q_valid   = req.valid;

  // length clamp and byte mask
  always_comb begin
    len_clamped = (req.length > 8'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES) : req.length[3:0];
  end

  always_comb begin
    q_data          = '0;
    q_data.port     = req.port;
    q_data.in_range = ({1'b0, req.port} < 9'(NUM_PORTS));
    q_data.owner_id = req.owner_id;
    q_data.sender   = req.sender;
    q_data.msg_type = req.msg_type;
    q_data.length   = len_clamped;
    q_data.time_now = req.time_now;
    for (int b = 0; b < 8; b++) begin
      q_data.payload[8*b +: 8] = (4'(b) < len_clamped) ? req.payload[8*b +: 8] : 8'h00;
    end
    unique case (req.action)
      ACT_CREATE:  q_data.op = OP_CREATE;
      ACT_DESTROY: q_data.op = OP_DESTROY;
      ACT_SEND:    q_data.op = OP_SEND;
      ACT_RECV:    q_data.op = OP_RECV;
      ACT_QUERY:   q_data.op = OP_QUERY;
      default:     q_data.op = OP_BAD;
    endcase
  end
endmodule

[rtl/pmm_fifo.sv]
// Short request queue between front and back
module pmm_fifo #(
  parameter int DEPTH = pmm_pkg::FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  pmm_pkg::req_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output pmm_pkg::req_t rd_data
);
  import pmm_pkg::*;

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  req_t            mem [DEPTH];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [CNTW-1:0] count;
  logic            push;
  logic            pop;

  assign wr_ready = (count != CNTW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNTW'(push) - CNTW'(pop);
    end
  end
endmodule

[rtl/pmm_back.sv]
// Back end: port table, per-port ring pointers, message memory and result register
`include "assert_macros.svh"
module pmm_back #(
  parameter int NUM_PORTS   = pmm_pkg::NUM_PORTS_DEF,
  parameter int QUEUE_DEPTH = pmm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  pmm_pkg::req_t q_data,
  pmm_rsp_if.source     rsp
);
  import pmm_pkg::*;

  localparam int PW   = $clog2(NUM_PORTS);
  localparam int QW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int TW   = $clog2(NUM_PORTS + 1);
  localparam int AW   = $clog2(NUM_PORTS * QUEUE_DEPTH);
  localparam int PTRW = 2 * QW + CW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_MSG  = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  req_t              cur;
  logic [PW-1:0]     pidx;
  logic [PW-1:0]     free_idx;
  logic              free_found;
  logic [PW-1:0]     srch_idx;
  logic              srch_found;
  logic [NUM_PORTS-1:0] port_active;
  logic [TW-1:0]     active_total;
  logic [31:0]       owner_mem [NUM_PORTS];
  logic [PTRW-1:0]   ptr_mem [NUM_PORTS];
  msg_t              msg_mem [NUM_PORTS * QUEUE_DEPTH];
  logic [31:0]       owner_rd;
  logic [PTRW-1:0]   ptr_rd;
  msg_t              msg_rd;
  rsp_t              rsp_q;
  logic              rsp_valid;
  logic              take;

  // EXEC decode
  logic [QW-1:0]     head;
  logic [QW-1:0]     tail;
  logic [CW-1:0]     cnt;
  logic              ok;
  logic              ptr_we;
  logic [PW-1:0]     ptr_wa;
  logic [PTRW-1:0]   ptr_wd;
  logic              own_we;
  logic              msg_we;
  logic              msg_re;
  logic [AW-1:0]     msg_addr;
  logic              act_set;
  logic              act_clr;
  logic [PW-1:0]     act_idx;
  logic [TW-1:0]     total_next;
  logic [CW-1:0]     cnt_after;
  logic              act_after;
  rsp_t              res;

  assign take    = (state == S_IDLE) && q_valid && !rsp_valid;
  assign q_ready = take;

  // lowest inactive port
  always_comb begin
    srch_found = 1'b0;
    srch_idx   = '0;
    for (int i = NUM_PORTS - 1; i >= 0; i--) begin
      if (!port_active[i]) begin
        srch_found = 1'b1;
        srch_idx   = PW'(i);
      end
    end
  end

  assign head = ptr_rd[PTRW-1 -: QW];
  assign tail = ptr_rd[CW +: QW];
  assign cnt  = ptr_rd[CW-1:0];
  assign ok   = cur.in_range && port_active[pidx];

  // request execution
  always_comb begin
    ptr_we     = 1'b0;
    ptr_wa     = pidx;
    ptr_wd     = ptr_rd;
    own_we     = 1'b0;
    msg_we     = 1'b0;
    msg_re     = 1'b0;
    msg_addr   = AW'(pidx) * AW'(QUEUE_DEPTH) + AW'(tail);
    act_set    = 1'b0;
    act_clr    = 1'b0;
    act_idx    = pidx;
    total_next = active_total;
    cnt_after  = cnt;
    act_after  = ok;
    res        = '0;
    res.status = ST_OK;
    unique case (cur.op)
      OP_CREATE: begin
        if (free_found) begin
          ptr_we       = 1'b1;
          ptr_wa       = free_idx;
          ptr_wd       = '0;
          own_we       = 1'b1;
          act_set      = 1'b1;
          act_idx      = free_idx;
          total_next   = active_total + 1'b1;
          res.new_port = 6'(free_idx);
          if (cur.in_range && free_idx == pidx) begin
            act_after = 1'b1;
            cnt_after = '0;
          end
        end else begin
          res.status = ST_NOFREE;
        end
      end
      OP_DESTROY: begin
        if (ok) begin
          ptr_we     = 1'b1;
          ptr_wd     = '0;
          act_clr    = 1'b1;
          total_next = active_total - 1'b1;
          act_after  = 1'b0;
        end else begin
          res.status = ST_INVALID;
        end
      end
      OP_SEND: begin
        if (!ok) begin
          res.status = ST_INVALID;
        end else if (cnt == CW'(QUEUE_DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          msg_we    = 1'b1;
          ptr_we    = 1'b1;
          cnt_after = cnt + 1'b1;
          ptr_wd    = {head, (tail == QW'(QUEUE_DEPTH - 1)) ? QW'(0) : tail + 1'b1,
                       cnt_after};
        end
      end
      OP_RECV: begin
        if (!ok) begin
          res.status = ST_INVALID;
        end else if (cnt == '0) begin
          res.status = ST_EMPTY;
        end else begin
          msg_re           = 1'b1;
          msg_addr         = AW'(pidx) * AW'(QUEUE_DEPTH) + AW'(head);
          ptr_we           = 1'b1;
          cnt_after        = cnt - 1'b1;
          ptr_wd           = {(head == QW'(QUEUE_DEPTH - 1)) ? QW'(0) : head + 1'b1, tail,
                              cnt_after};
          res.receiver_out = owner_rd;
        end
      end
      OP_QUERY: begin
        if (!ok) begin
          res.status = ST_INVALID;
        end
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
    if (act_after) begin
      res.count_out    = 5'(cnt_after);
      res.has_messages = (cnt_after != '0);
    end
    res.active_ports = 7'(total_next);
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (take) state_next = S_EXEC;
      S_EXEC:  state_next = msg_re ? S_MSG : S_IDLE;
      S_MSG:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request latch and table reads
  always_ff @(posedge clk) begin
    if (take) begin
      cur        <= q_data;
      pidx       <= q_data.port[PW-1:0];
      free_idx   <= srch_idx;
      free_found <= srch_found;
      ptr_rd     <= ptr_mem[q_data.port[PW-1:0]];
      owner_rd   <= owner_mem[q_data.port[PW-1:0]];
    end
  end

  // table writes
  always_ff @(posedge clk) begin
    if (state == S_EXEC && ptr_we) begin
      ptr_mem[ptr_wa] <= ptr_wd;
    end
    if (state == S_EXEC && own_we) begin
      owner_mem[free_idx] <= cur.owner_id;
    end
  end

  // message memory
  always_ff @(posedge clk) begin
    if (state == S_EXEC && msg_we) begin
      msg_mem[msg_addr] <= '{sender: cur.sender, msg_type: cur.msg_type,
                             payload: cur.payload, length: cur.length,
                             time_now: cur.time_now};
    end
    if (state == S_EXEC && msg_re) begin
      msg_rd <= msg_mem[msg_addr];
    end
  end

  // active flags and count
  always_ff @(posedge clk) begin
    if (rst) begin
      port_active  <= '0;
      active_total <= '0;
    end else if (state == S_EXEC) begin
      if (act_set) port_active[act_idx] <= 1'b1;
      if (act_clr) port_active[act_idx] <= 1'b0;
      active_total <= total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      rsp_q <= res;
    end else if (state == S_MSG) begin
      rsp_q.sender_out  <= msg_rd.sender;
      rsp_q.type_out    <= msg_rd.msg_type;
      rsp_q.payload_out <= msg_rd.payload;
      rsp_q.length_out  <= msg_rd.length;
      rsp_q.time_out    <= msg_rd.time_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_EXEC && !msg_re) || state == S_MSG) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_q.status;
  assign rsp.new_port     = rsp_q.new_port;
  assign rsp.sender_out   = rsp_q.sender_out;
  assign rsp.receiver_out = rsp_q.receiver_out;
  assign rsp.type_out     = rsp_q.type_out;
  assign rsp.payload_out  = rsp_q.payload_out;
  assign rsp.length_out   = rsp_q.length_out;
  assign rsp.time_out     = rsp_q.time_out;
  assign rsp.count_out    = rsp_q.count_out;
  assign rsp.has_messages = rsp_q.has_messages;
  assign rsp.active_ports = rsp_q.active_ports;

  `ASSERT_IMPL(a_total_matches, clk, rst, 1'b1, TW'($countones(port_active)) == active_total)
  `ASSERT_IMPL(a_exec_after_idle, clk, rst, state == S_EXEC, $past(state) == S_IDLE)
  `ASSERT_NEXT(a_msg_gives_result, clk, rst, state == S_MSG, rsp_valid)
  `ASSERT_IMPL(a_take_only_empty, clk, rst, take, !rsp_valid)
endmodule

[rtl/port_message_mailbox_top.sv]
// Port message mailbox: each request passes the table read and execute steps of the
// back end, a receive that returns a message also the message memory read step; the
// result transfer must complete before the back end takes the next request.
// The result is registered; a 2-entry queue decouples the input.
// Synchronous active-high reset clears port flags, active count and the request queue's control;
// pointer and message memories need no clearing pass; a port's pointers are set up on create.
module port_message_mailbox_top #(
  parameter int NUM_PORTS     = pmm_pkg::NUM_PORTS_DEF,
  parameter int QUEUE_DEPTH   = pmm_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BYTES = pmm_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pmm_req_if.sink   req,
  pmm_rsp_if.source rsp
);
  import pmm_pkg::*;

  logic f_valid;
  logic f_ready;
  req_t f_data;
  logic b_valid;
  logic b_ready;
  req_t b_data;

  pmm_front #(.NUM_PORTS(NUM_PORTS), .PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
    .req     (req),
    .q_ready (f_ready),
    .q_valid (f_valid),
    .q_data  (f_data)
  );

  pmm_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  pmm_back #(.NUM_PORTS(NUM_PORTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_data  (b_data),
    .rsp     (rsp)
  );
endmodule
